>>> hdl/dmf_pkg.sv
// Shared types, codes and helper functions for the drive mixer with failsafe.
package dmf_pkg;

    // Register reset values
    localparam logic [14:0] DEADBAND_RST  = 15'd50;
    localparam logic [14:0] MAX_SPEED_RST = 15'd1000;
    localparam logic [15:0] TIMEOUT_RST   = 16'd500;
    localparam logic        FS_EN_RST     = 1'b1;

    // Elapsed counter saturates at all ones
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    // Divider geometry: |side| * max_speed over the larger magnitude
    localparam int DIV_DIVIDEND_W = 32;
    localparam int DIV_DIVISOR_W  = 17;
    localparam int DIV_QUOT_W     = 15;
    localparam int DIV_CNT_W      = 4;

    typedef enum logic [3:0] {
        REQ_TANK    = 4'd0,
        REQ_ARCADE  = 4'd1,
        REQ_LEFT    = 4'd2,
        REQ_RIGHT   = 4'd3,
        REQ_WEAPON  = 4'd4,
        REQ_ARM     = 4'd5,
        REQ_DISARM  = 4'd6,
        REQ_STOP    = 4'd7,
        REQ_TICK    = 4'd8
    } req_t;

    typedef enum logic [1:0] {
        CFG_DEADBAND  = 2'd0,
        CFG_MAX_SPEED = 2'd1,
        CFG_TIMEOUT   = 2'd2,
        CFG_FS_EN     = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    // Divider handshake status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Magnitude of an 18 bit signed value
    function automatic logic [17:0] mag18(input logic signed [17:0] v);
        return v[17] ? 18'(-v) : 18'(v);
    endfunction

    // Zero below the deadband, then clamp to plus or minus the limit
    function automatic logic signed [15:0] shape(input logic signed [17:0] v,
                                                 input logic [14:0] db,
                                                 input logic [14:0] lim);
        logic signed [17:0] lim_s;
        logic signed [17:0] r;
        lim_s = signed'({3'b000, lim});
        r = v;
        if (mag18(v) < {3'b000, db})
            r = '0;
        if (r > lim_s)
            r = lim_s;
        if (r < -lim_s)
            r = -lim_s;
        return r[15:0];
    endfunction

endpackage

>>> hdl/dmf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module dmf_div
    import dmf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIV_DIVIDEND_W-1:0] dividend,
    input  logic [DIV_DIVISOR_W-1:0]  divisor,
    output div_stat_t                 stat,
    output logic [DIV_QUOT_W-1:0]     quotient
);

    logic [DIV_DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIV_QUOT_W-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [DIV_DIVISOR_W:0]   trial;
    logic [DIV_DIVISOR_W:0]   diff;
    logic                     ge;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_QUOT_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // Load on start, then shift one quotient bit in per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // High dividend bits are already below the divisor
            rem_next  = dividend[DIV_DIVIDEND_W-1:DIV_QUOT_W];
            quo_next  = dividend[DIV_QUOT_W-1:0];
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_DIVISOR_W-1:0] : trial[DIV_DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_QUOT_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> hdl/drive_mixer_with_failsafe_core.sv
// Top level of the drive mixer with command timeout failsafe.
//
// Each request yields one result: the drive, weapon, armed and failsafe state
// after the request. Tank, left, right, weapon, arm, disarm, stop-all and tick
// requests go from execute straight to the result. An arcade request whose
// mix exceeds max speed is rescaled through one shared 15-step restoring
// divider, once per side. The block takes one request at a time; a finished
// result sits in an output register so a new request can be accepted while
// it waits. Configuration writes go straight to the registers and are meant
// for idle.
module drive_mixer_with_failsafe_core
    import dmf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         req_type,
    input  logic signed [15:0] value_a,
    input  logic signed [15:0] value_b,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic [14:0]        weapon_out,
    output logic               armed_out,
    output logic               failsafe_active,
    // Configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    state_t state_reg, state_next;

    // Configuration
    logic [14:0] deadband_reg;
    logic [14:0] max_speed_reg;
    logic [15:0] timeout_reg;
    logic        fs_en_reg;

    // Architectural state
    logic signed [15:0] left_speed_reg, left_speed_next;
    logic signed [15:0] right_speed_reg, right_speed_next;
    logic [14:0]        weapon_speed_reg, weapon_speed_next;
    logic               armed_reg, armed_next;
    logic               latched_reg, latched_next;
    logic [16:0]        elapsed_reg, elapsed_next;

    // Working registers
    logic [3:0]         req_reg, req_next;
    logic signed [15:0] a_reg, a_next;
    logic signed [15:0] b_reg, b_next;
    logic signed [17:0] mix_l_reg, mix_l_next;
    logic signed [17:0] mix_r_reg, mix_r_next;
    logic [16:0]        big_reg, big_next;
    logic               side_reg, side_next;
    logic [14:0]        q_l_reg, q_l_next;

    // Result registers
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] left_out_reg;
    logic signed [15:0] right_out_reg;
    logic [14:0]        weapon_out_reg;
    logic               armed_out_reg;
    logic               fs_out_reg;

    // Control
    logic in_fire;
    logic slot_free;
    logic out_load;
    logic div_start;
    logic arc_scale;

    // Arcade mix
    logic signed [17:0] a18, b18;
    logic signed [17:0] thr, trn;
    logic signed [17:0] mix_l, mix_r;
    logic [17:0]        mag_l, mag_r;
    logic [17:0]        big;

    // Scaling datapath
    logic [17:0]        mag_sel;
    logic [31:0]        prod;
    logic [16:0]        div_dvs;
    div_stat_t          div_stat;
    logic [14:0]        div_q;
    logic signed [17:0] ql18, qr18;
    logic signed [17:0] scaled_l, scaled_r;

    // Tick
    logic [16:0] elapsed_inc;
    logic        fs_fire;

    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Mix throttle and turn after the deadband
    always_comb
    begin
        a18   = signed'({{2{a_reg[15]}}, a_reg});
        b18   = signed'({{2{b_reg[15]}}, b_reg});
        thr   = (mag18(a18) < {3'b000, deadband_reg}) ? 18'sd0 : a18;
        trn   = (mag18(b18) < {3'b000, deadband_reg}) ? 18'sd0 : b18;
        mix_l = thr + trn;
        mix_r = thr - trn;
        mag_l = mag18(mix_l);
        mag_r = mag18(mix_r);
        big   = (mag_l > mag_r) ? mag_l : mag_r;
        arc_scale = (big > {3'b000, max_speed_reg});
    end

    // Multiply one side magnitude by max speed for the divider
    always_comb
    begin
        mag_sel  = side_reg ? mag18(mix_r_reg) : mag18(mix_l_reg);
        prod     = 32'(mag_sel[16:0]) * 32'(max_speed_reg);
        div_dvs  = big_reg;
        ql18     = signed'({3'b000, q_l_reg});
        qr18     = signed'({3'b000, div_q});
        scaled_l = mix_l_reg[17] ? -ql18 : ql18;
        scaled_r = mix_r_reg[17] ? -qr18 : qr18;
    end

    // Advance and saturate the elapsed counter
    always_comb
    begin
        elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 17'd1 : elapsed_reg;
        fs_fire     = fs_en_reg && (elapsed_inc > {1'b0, timeout_reg}) && !latched_reg;
    end

    dmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (div_dvs),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if ((req_reg == REQ_ARCADE) && arc_scale)
                    state_next = S_MUL;
                else
                    state_next = S_DONE;
            end
            S_MUL:
                state_next = S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = side_reg ? S_DONE : S_MUL;
            end
            S_DONE:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        div_start = (state_reg == S_MUL);
        out_load  = (state_reg == S_DONE) && slot_free;
    end

    // Datapath updates
    always_comb
    begin
        left_speed_next   = left_speed_reg;
        right_speed_next  = right_speed_reg;
        weapon_speed_next = weapon_speed_reg;
        armed_next        = armed_reg;
        latched_next      = latched_reg;
        elapsed_next      = elapsed_reg;
        req_next          = req_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        mix_l_next        = mix_l_reg;
        mix_r_next        = mix_r_reg;
        big_next          = big_reg;
        side_next         = side_reg;
        q_l_next          = q_l_reg;

        // Capture the request
        if ((state_reg == S_IDLE) && in_fire)
        begin
            req_next = req_type;
            a_next   = value_a;
            b_next   = value_b;
        end

        // Execute the request
        if (state_reg == S_EXEC)
        begin
            unique case (req_reg)
                REQ_TANK:
                begin
                    left_speed_next  = shape(a18, deadband_reg, max_speed_reg);
                    right_speed_next = shape(b18, deadband_reg, max_speed_reg);
                    elapsed_next     = '0;
                    latched_next     = 1'b0;
                end
                REQ_ARCADE:
                begin
                    mix_l_next = mix_l;
                    mix_r_next = mix_r;
                    big_next   = big[16:0];
                    side_next  = 1'b0;
                    if (!arc_scale)
                    begin
                        left_speed_next  = shape(mix_l, deadband_reg, max_speed_reg);
                        right_speed_next = shape(mix_r, deadband_reg, max_speed_reg);
                        elapsed_next     = '0;
                        latched_next     = 1'b0;
                    end
                end
                REQ_LEFT:
                begin
                    left_speed_next = shape(a18, deadband_reg, max_speed_reg);
                    elapsed_next    = '0;
                    latched_next    = 1'b0;
                end
                REQ_RIGHT:
                begin
                    right_speed_next = shape(a18, deadband_reg, max_speed_reg);
                    elapsed_next     = '0;
                    latched_next     = 1'b0;
                end
                REQ_WEAPON:
                begin
                    if (a_reg[15])
                        weapon_speed_next = '0;
                    else if (a_reg[14:0] > max_speed_reg)
                        weapon_speed_next = max_speed_reg;
                    else
                        weapon_speed_next = a_reg[14:0];
                    elapsed_next = '0;
                    latched_next = 1'b0;
                end
                REQ_ARM:
                    armed_next = 1'b1;
                REQ_DISARM:
                begin
                    armed_next        = 1'b0;
                    weapon_speed_next = '0;
                end
                REQ_STOP:
                begin
                    left_speed_next   = '0;
                    right_speed_next  = '0;
                    weapon_speed_next = '0;
                    armed_next        = 1'b0;
                end
                REQ_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (fs_fire)
                    begin
                        left_speed_next   = '0;
                        right_speed_next  = '0;
                        weapon_speed_next = '0;
                        armed_next        = 1'b0;
                        latched_next      = 1'b1;
                    end
                end
                default:
                begin
                    // Unused codes change nothing
                end
            endcase
        end

        // Collect the scaled sides
        if ((state_reg == S_DIV) && div_stat.done)
        begin
            if (!side_reg)
            begin
                q_l_next  = div_q;
                side_next = 1'b1;
            end
            else
            begin
                left_speed_next  = shape(scaled_l, deadband_reg, max_speed_reg);
                right_speed_next = shape(scaled_r, deadband_reg, max_speed_reg);
                elapsed_next     = '0;
                latched_next     = 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RST;
            max_speed_reg <= MAX_SPEED_RST;
            timeout_reg   <= TIMEOUT_RST;
            fs_en_reg     <= FS_EN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEADBAND:  deadband_reg  <= cfg_data[14:0];
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[14:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                CFG_FS_EN:     fs_en_reg     <= cfg_data[0];
            endcase
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            left_speed_reg   <= '0;
            right_speed_reg  <= '0;
            weapon_speed_reg <= '0;
            armed_reg        <= 1'b1;
            latched_reg      <= 1'b0;
            elapsed_reg      <= '0;
            req_reg          <= '0;
            side_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            left_speed_reg   <= left_speed_next;
            right_speed_reg  <= right_speed_next;
            weapon_speed_reg <= weapon_speed_next;
            armed_reg        <= armed_next;
            latched_reg      <= latched_next;
            elapsed_reg      <= elapsed_next;
            req_reg          <= req_next;
            side_reg         <= side_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        mix_l_reg <= mix_l_next;
        mix_r_reg <= mix_r_next;
        big_reg   <= big_next;
        q_l_reg   <= q_l_next;
        if (out_load)
        begin
            left_out_reg   <= left_speed_reg;
            right_out_reg  <= right_speed_reg;
            weapon_out_reg <= weapon_speed_reg;
            armed_out_reg  <= armed_reg;
            fs_out_reg     <= fs_en_reg && (elapsed_reg > {1'b0, timeout_reg});
        end
    end

    assign out_valid       = out_valid_reg;
    assign left_out        = left_out_reg;
    assign right_out       = right_out_reg;
    assign weapon_out      = weapon_out_reg;
    assign armed_out       = armed_out_reg;
    assign failsafe_active = fs_out_reg;

endmodule
